// ===== sv/fcu_pkg.sv =====
// Package: opcodes, payload types and conversion functions for the format converter.
package fcu_pkg;

  typedef enum logic [1:0] {
    OP_UNPACK = 2'd0,
    OP_PACK   = 2'd1,
    OP_I2F    = 2'd2,
    OP_F2I    = 2'd3
  } fcu_op_t;

  localparam logic [7:0] F2I_EXP_MAX = 8'h9D;
  localparam logic [7:0] EXP_BIAS    = 8'd127;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] source_low;
    logic [63:0] source_high;
    logic        fpu_usable;
  } fcu_in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        write_enable;
    logic        fpu_unusable_fault;
  } fcu_out_t;

  function automatic logic [31:0] unpack_half(input logic [15:0] p);
    unpack_half = {p[15], 7'd0, p[14:10], 3'd0, p[9:5], 3'd0, p[4:0], 3'd0};
  endfunction

  function automatic logic [15:0] pack_word(input logic [31:0] w);
    pack_word = {w[31], w[23:19], w[15:11], w[7:3]};
  endfunction

endpackage

// ===== sv/format_convert_unit_core.sv =====
// Top level: registered single-pass format converter.
//   channel | ports                      | handshake
//   input   | in_payload                 | start & !busy
//   result  | out_payload                | out_valid, one cycle
// One item per cycle; the result passes through the input register
// and then the result register. busy is held low: the result side
// cannot stall. Reset clears the valid flags only.
module format_convert_unit_core import fcu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fcu_in_t  in_payload,
  output logic     out_valid,
  output fcu_out_t out_payload
);
  fcu_in_t     in_r;
  logic        in_vld_r, out_vld_r;
  fcu_out_t    out_r, out_nxt;
  logic [31:0] i2f_res, f2i_res;

  assign busy = 1'b0;

  fcu_i2f u_i2f (.value(in_r.source_low[31:0]), .result(i2f_res));
  fcu_f2i u_f2i (.value(in_r.source_low[31:0]), .result(f2i_res));

  always_comb begin
    out_nxt = '0;
    out_nxt.write_enable = 1'b1;
    case (fcu_op_t'(in_r.opcode))
      OP_UNPACK: begin
        out_nxt.result_low  = {unpack_half(in_r.source_low[47:32]),
                               unpack_half(in_r.source_low[15:0])};
        out_nxt.result_high = {unpack_half(in_r.source_high[47:32]),
                               unpack_half(in_r.source_high[15:0])};
      end
      OP_PACK: begin
        out_nxt.result_low  = {16'd0, pack_word(in_r.source_low[63:32]),
                               16'd0, pack_word(in_r.source_low[31:0])};
        out_nxt.result_high = {16'd0, pack_word(in_r.source_high[63:32]),
                               16'd0, pack_word(in_r.source_high[31:0])};
      end
      default: begin
        if (!in_r.fpu_usable) begin
          out_nxt.write_enable       = 1'b0;
          out_nxt.fpu_unusable_fault = 1'b1;
        end else if (fcu_op_t'(in_r.opcode) == OP_I2F) begin
          out_nxt.result_low = {32'd0, i2f_res};
        end else begin
          out_nxt.result_low = {32'd0, f2i_res};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_r <= in_payload;
    if (in_vld_r) out_r <= out_nxt;
  end

  assign out_valid   = out_vld_r;
  assign out_payload = out_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("result missing");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload.write_enable && out_payload.fpu_unusable_fault))
    else $error("write and fault together");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.fpu_unusable_fault) |->
      (out_payload.result_low == 64'd0 && out_payload.result_high == 64'd0))
    else $error("faulted result not zero");
endmodule

// ===== sv/fcu_i2f.sv =====
// Signed 32-bit integer to single-precision float, round to nearest even.
module fcu_i2f import fcu_pkg::*; (
  input  logic [31:0] value,
  output logic [31:0] result
);
  logic        sign;
  logic [31:0] mag;
  logic [4:0]  msb;
  logic [31:0] norm;
  logic        guard, sticky, round_up;
  logic [24:0] mant;
  logic [7:0]  expo;

  always_comb begin
    sign = value[31];
    mag  = sign ? (32'd0 - value) : value;
    msb  = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    // normalize leading one to bit 31
    norm     = mag << (5'd31 - msb);
    guard    = norm[7];
    sticky   = |norm[6:0];
    round_up = guard && (sticky || norm[8]);
    mant     = {1'b0, norm[31:8]} + {24'd0, round_up};
    expo     = EXP_BIAS + {3'd0, msb} + {7'd0, mant[24]};
    if (mag == 32'd0) begin
      result = 32'd0;
    end else begin
      result = {sign, expo, mant[24] ? mant[23:1] : mant[22:0]};
    end
  end
endmodule

// ===== sv/fcu_f2i.sv =====
// Single-precision float to signed 32-bit integer, truncating, with clamping.
module fcu_f2i import fcu_pkg::*; (
  input  logic [31:0] value,
  output logic [31:0] result
);
  logic [7:0]  e;
  logic [31:0] mant;
  logic [31:0] mag;

  always_comb begin
    e    = value[30:23];
    mant = {8'd0, 1'b1, value[22:0]};
    if (e >= 8'd150) mag = mant << 5'(e - 8'd150);
    else             mag = mant >> 5'(8'd150 - e);
    if (e > F2I_EXP_MAX)    result = value[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (e < EXP_BIAS)  result = 32'd0;
    else                    result = value[31] ? (32'd0 - mag) : mag;
  end
endmodule
